// ===== hw/rtl/double_ended_queue_with_delete_macros.svh =====
// Assertion macros used by the deque top level.
`ifndef DOUBLE_ENDED_QUEUE_WITH_DELETE_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_WITH_DELETE_MACROS_SVH

// Same-cycle implication, clocked on clk_i and disabled during reset.
`define DQD_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk_i and disabled during reset.
`define DQD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/dqd_pkg.sv =====
// Package of types, codes and default sizes for the deque with delete.
`timescale 1ns / 1ps

package dqd_pkg;

  localparam int DEPTH_DEF      = 16;
  localparam int DATA_WIDTH_DEF = 32;
  localparam int ACT_W          = 3;
  localparam int VALUE_W        = 32;
  localparam int DOUT_W         = 32;
  localparam int STATUS_W       = 2;
  localparam int OCC_W          = 5;

  typedef enum logic [ACT_W-1:0] {
    ACT_PUSH_BACK  = 3'd0,
    ACT_POP_BACK   = 3'd1,
    ACT_PUSH_FRONT = 3'd2,
    ACT_POP_FRONT  = 3'd3,
    ACT_DELETE     = 3'd4,
    ACT_COUNT      = 3'd5
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  typedef struct packed {
    logic [ACT_W-1:0]   action;
    logic [VALUE_W-1:0] value;
  } in_t;

  typedef struct packed {
    logic [DOUT_W-1:0]   data_out;
    logic [STATUS_W-1:0] status;
    logic [OCC_W-1:0]    occupancy;
  } out_t;

endpackage

// ===== hw/rtl/dqd_ram.sv =====
// Entry store: one write port and one read port with registered read data.
`timescale 1ns / 1ps

module dqd_ram #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32,
  localparam int AW        = $clog2(DEPTH)
) (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic [AW-1:0]         waddr_i,
  input  logic [DATA_WIDTH-1:0] wdata_i,
  input  logic                  re_i,
  input  logic [AW-1:0]         raddr_i,
  output logic [DATA_WIDTH-1:0] rdata_o
);

  logic [DATA_WIDTH-1:0] mem_q [DEPTH];
  logic [DATA_WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/dqd_ctrl.sv =====
// Sequencer that runs each deque action as reads and writes of the entry store.
`timescale 1ns / 1ps

module dqd_ctrl import dqd_pkg::*; #(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  localparam int AW        = $clog2(DEPTH),
  localparam int CW        = $clog2(DEPTH + 1)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_t                   in_i,
  input  logic                  slot_free_i,
  output logic                  res_valid_o,
  output out_t                  res_o,
  output logic                  mem_we_o,
  output logic [AW-1:0]         mem_waddr_o,
  output logic [DATA_WIDTH-1:0] mem_wdata_o,
  output logic                  mem_re_o,
  output logic [AW-1:0]         mem_raddr_o,
  input  logic [DATA_WIDTH-1:0] mem_rdata_i
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_WAIT,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_SH_RD,
    S_SH_WR,
    S_RESP
  } state_e;

  state_e                state_q;
  logic [AW-1:0]         front_q;
  logic [CW-1:0]         count_q;
  logic [CW-1:0]         idx_q;
  logic [DATA_WIDTH-1:0] word_q;
  logic [DATA_WIDTH-1:0] data_q;
  status_e               status_q;

  logic                  accept;
  logic                  full;
  logic                  empty;
  logic [63:0]           value_wide;
  logic [63:0]           data_wide;
  logic [DATA_WIDTH-1:0] word;
  logic [CW-1:0]         cnt_m1;
  logic [CW-1:0]         idx_p1;
  logic [CW-1:0]         idx_p2;
  logic [AW-1:0]         front_inc;
  logic [AW-1:0]         front_dec;

  function automatic logic [AW-1:0] ring_pos(input logic [AW-1:0] base,
                                             input logic [AW-1:0] ofs);
    logic [AW:0] sum;
    sum = {1'b0, base} + {1'b0, ofs};
    if (sum >= (AW+1)'(DEPTH)) begin
      sum = sum - (AW+1)'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  assign accept     = in_valid_i && (state_q == S_IDLE);
  assign in_stall_o = (state_q != S_IDLE);
  assign full       = (count_q == CW'(DEPTH));
  assign empty      = (count_q == '0);
  assign value_wide = 64'(in_i.value);
  assign word       = value_wide[DATA_WIDTH-1:0];
  assign cnt_m1     = count_q - 1'b1;
  assign idx_p1     = idx_q + 1'b1;
  assign idx_p2     = idx_p1 + 1'b1;
  assign front_inc  = (front_q == AW'(DEPTH - 1)) ? '0 : front_q + 1'b1;
  assign front_dec  = (front_q == '0) ? AW'(DEPTH - 1) : front_q - 1'b1;

  always_comb begin
    mem_we_o    = 1'b0;
    mem_waddr_o = '0;
    mem_wdata_o = word;
    mem_re_o    = 1'b0;
    mem_raddr_o = '0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (in_i.action)
            ACT_PUSH_BACK: begin
              mem_we_o    = !full;
              mem_waddr_o = ring_pos(front_q, count_q[AW-1:0]);
            end
            ACT_PUSH_FRONT: begin
              mem_we_o    = !full;
              mem_waddr_o = front_dec;
            end
            ACT_POP_BACK: begin
              mem_re_o    = !empty;
              mem_raddr_o = ring_pos(front_q, cnt_m1[AW-1:0]);
            end
            ACT_POP_FRONT: begin
              mem_re_o    = !empty;
              mem_raddr_o = front_q;
            end
            default: ;
          endcase
        end
      end
      S_SCAN_RD: begin
        mem_re_o    = 1'b1;
        mem_raddr_o = ring_pos(front_q, idx_q[AW-1:0]);
      end
      S_SH_RD: begin
        mem_re_o    = 1'b1;
        mem_raddr_o = ring_pos(front_q, idx_p1[AW-1:0]);
      end
      S_SH_WR: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = ring_pos(front_q, idx_q[AW-1:0]);
        mem_wdata_o = mem_rdata_i;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      front_q  <= '0;
      count_q  <= '0;
      idx_q    <= '0;
      word_q   <= '0;
      data_q   <= '0;
      status_q <= ST_OK;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            word_q   <= word;
            data_q   <= '0;
            status_q <= ST_OK;
            state_q  <= S_RESP;
            case (in_i.action)
              ACT_PUSH_BACK: begin
                if (full) begin
                  status_q <= ST_FULL;
                end else begin
                  count_q <= count_q + 1'b1;
                end
              end
              ACT_PUSH_FRONT: begin
                if (full) begin
                  status_q <= ST_FULL;
                end else begin
                  front_q <= front_dec;
                  count_q <= count_q + 1'b1;
                end
              end
              ACT_POP_BACK: begin
                if (empty) begin
                  status_q <= ST_EMPTY;
                end else begin
                  count_q <= cnt_m1;
                  state_q <= S_RD_WAIT;
                end
              end
              ACT_POP_FRONT: begin
                if (empty) begin
                  status_q <= ST_EMPTY;
                end else begin
                  front_q <= front_inc;
                  count_q <= cnt_m1;
                  state_q <= S_RD_WAIT;
                end
              end
              ACT_DELETE: begin
                if (empty) begin
                  status_q <= ST_NOT_FOUND;
                end else begin
                  idx_q   <= '0;
                  state_q <= S_SCAN_RD;
                end
              end
              default: ;
            endcase
          end
        end
        S_RD_WAIT: begin
          data_q  <= mem_rdata_i;
          state_q <= S_RESP;
        end
        S_SCAN_RD: begin
          state_q <= S_SCAN_CMP;
        end
        S_SCAN_CMP: begin
          if (mem_rdata_i == word_q) begin
            if (idx_p1 < count_q) begin
              state_q <= S_SH_RD;
            end else begin
              count_q <= cnt_m1;
              state_q <= S_RESP;
            end
          end else if (idx_p1 < count_q) begin
            idx_q   <= idx_p1;
            state_q <= S_SCAN_RD;
          end else begin
            status_q <= ST_NOT_FOUND;
            state_q  <= S_RESP;
          end
        end
        S_SH_RD: begin
          state_q <= S_SH_WR;
        end
        S_SH_WR: begin
          if (idx_p2 < count_q) begin
            idx_q   <= idx_p1;
            state_q <= S_SH_RD;
          end else begin
            count_q <= cnt_m1;
            state_q <= S_RESP;
          end
        end
        S_RESP: begin
          if (slot_free_i) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign data_wide       = 64'(data_q);
  assign res_valid_o     = (state_q == S_RESP) && slot_free_i;
  assign res_o.data_out  = data_wide[DOUT_W-1:0];
  assign res_o.status    = status_q;
  assign res_o.occupancy = OCC_W'(count_q);

endmodule

// ===== hw/rtl/double_ended_queue_with_delete.sv =====
// Push, push front and count go from acceptance straight to the result state.
// Pops pass a read wait state first; delete reads and compares each entry scanned up to the
// match and reads and writes each later entry moved, all set by the single read port of the store.
// The result waits while the output is stalled; the next beat is accepted once back in idle.
// Reset clears the front pointer, the count and the control; the store is not cleared.
`timescale 1ns / 1ps
`include "double_ended_queue_with_delete_macros.svh"

module double_ended_queue_with_delete import dqd_pkg::*; #(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_o
);

  localparam int AW = $clog2(DEPTH);

  logic                  out_valid_q;
  out_t                  out_q;
  logic                  slot_free;
  logic                  res_valid;
  out_t                  res;
  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [DATA_WIDTH-1:0] mem_wdata;
  logic                  mem_re;
  logic [AW-1:0]         mem_raddr;
  logic [DATA_WIDTH-1:0] mem_rdata;

  assign slot_free = !out_valid_q || !out_stall_i;

  dqd_ctrl #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_i        (in_i),
    .slot_free_i (slot_free),
    .res_valid_o (res_valid),
    .res_o       (res),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  dqd_ram #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  `DQD_ASSERT_IMPL(a_res_fits, res_valid, !out_valid_q || !out_stall_i, "result beat overwrote a waiting one")
  `DQD_ASSERT_NEXT(a_one_at_a_time, in_valid_i && !in_stall_o, in_stall_o, "second beat taken while busy")
  `DQD_ASSERT_IMPL(a_occ_bound, out_valid_o, out_o.occupancy <= DEPTH, "occupancy beyond depth")
  `DQD_ASSERT_IMPL(a_data_zero, out_valid_o && (out_o.status != ST_OK), out_o.data_out == '0, "data on a failed action")

endmodule

// ===== tb/sv/tb_double_ended_queue_with_delete.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the deque with delete, driven by directed and random requests.
module tb_double_ended_queue_with_delete;
  import dqd_pkg::*;

  localparam logic [ACT_W-1:0] ACT_SPARE_6 = 3'd6;
  localparam logic [ACT_W-1:0] ACT_SPARE_7 = 3'd7;
  localparam int RANDOM_ITEMS = 600;
  localparam int DRAIN_CYCLES = 200;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_t  in_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_t out_o;

  in_t                pending_requests[$];
  out_t               expected_results[$];
  logic [VALUE_W-1:0] deque_words[$];
  logic [VALUE_W-1:0] value_pool[8];
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int accepted_beats = 0;
  int mismatch_count = 0;

  double_ended_queue_with_delete #(
    .DEPTH      (DEPTH_DEF),
    .DATA_WIDTH (DATA_WIDTH_DEF)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_i        (in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic add_request(input logic [ACT_W-1:0] act, input logic [VALUE_W-1:0] v);
    in_t req;
    req.action = act;
    req.value  = v;
    pending_requests.push_back(req);
  endtask

  function automatic logic [VALUE_W-1:0] pick_value();
    if ($urandom_range(99) < 60) return value_pool[$urandom_range(7)];
    return $urandom();
  endfunction

  function automatic logic [ACT_W-1:0] random_action();
    int r;
    r = $urandom_range(99);
    if (r < 20) return ACT_PUSH_BACK;
    if (r < 35) return ACT_PUSH_FRONT;
    if (r < 48) return ACT_POP_BACK;
    if (r < 60) return ACT_POP_FRONT;
    if (r < 85) return ACT_DELETE;
    if (r < 96) return ACT_COUNT;
    if (r < 98) return ACT_SPARE_6;
    return ACT_SPARE_7;
  endfunction

  // Work out the result of one accepted request and update the deque contents.
  task automatic predict_deque_result(input in_t req);
    out_t res;
    int   hit;
    res = '0;
    res.status = ST_OK;
    case (req.action)
      ACT_PUSH_BACK, ACT_PUSH_FRONT: begin
        if (deque_words.size() >= DEPTH_DEF) res.status = ST_FULL;
        else if (req.action == ACT_PUSH_BACK) deque_words.push_back(req.value);
        else deque_words.push_front(req.value);
      end
      ACT_POP_BACK: begin
        if (deque_words.size() == 0) res.status = ST_EMPTY;
        else res.data_out = deque_words.pop_back();
      end
      ACT_POP_FRONT: begin
        if (deque_words.size() == 0) res.status = ST_EMPTY;
        else res.data_out = deque_words.pop_front();
      end
      ACT_DELETE: begin
        hit = -1;
        foreach (deque_words[i]) begin
          if (hit < 0 && deque_words[i] == req.value) hit = i;
        end
        if (hit < 0) res.status = ST_NOT_FOUND;
        else deque_words.delete(hit);
      end
      default: ;
    endcase
    res.occupancy = OCC_W'(deque_words.size());
    expected_results.push_back(res);
  endtask

  task automatic check_result(input out_t got);
    out_t want;
    if (expected_results.size() == 0) begin
      report_mismatch($sformatf("unexpected result beat %h", got));
    end else begin
      want = expected_results.pop_front();
      if (got.data_out !== want.data_out)
        report_mismatch($sformatf("data_out %h, expected %h", got.data_out, want.data_out));
      if (got.status !== want.status)
        report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
      if (got.occupancy !== want.occupancy)
        report_mismatch($sformatf("occupancy %0d, expected %0d", got.occupancy,
                                  want.occupancy));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_i       <= '0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        predict_deque_result(in_i);
        accepted_beats <= accepted_beats + 1;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid_i <= 1'b1;
          in_i       <= pending_requests.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) check_result(out_o);
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  initial begin
    int kind;
    int burst;
    int generated;
    int total;
    logic [ACT_W-1:0] act;

    value_pool[0] = '0;
    value_pool[1] = '1;
    for (int k = 2; k < 8; k++) value_pool[k] = $urandom();

    // Requests on an empty deque, then a short fill with extreme words and a delete
    // that has to close a gap in the middle.
    add_request(ACT_COUNT, 32'h0);
    add_request(ACT_POP_BACK, 32'hFFFF_FFFF);
    add_request(ACT_POP_FRONT, 32'h0);
    add_request(ACT_DELETE, 32'h0);
    add_request(ACT_PUSH_BACK, 32'h0000_0000);
    add_request(ACT_PUSH_FRONT, 32'hFFFF_FFFF);
    add_request(ACT_PUSH_BACK, 32'h8000_0000);
    add_request(ACT_PUSH_FRONT, 32'h0000_0001);
    add_request(ACT_PUSH_BACK, 32'hFFFF_FFFF);
    add_request(ACT_DELETE, 32'hFFFF_FFFF);
    add_request(ACT_DELETE, 32'h1234_5678);
    add_request(ACT_SPARE_6, 32'hA5A5_A5A5);
    add_request(ACT_SPARE_7, 32'h5A5A_5A5A);
    add_request(ACT_COUNT, 32'hFFFF_FFFF);
    add_request(ACT_POP_FRONT, 32'h0);
    add_request(ACT_POP_BACK, 32'h0);
    add_request(ACT_DELETE, 32'h8000_0000);
    add_request(ACT_DELETE, 32'hFFFF_FFFF);
    add_request(ACT_POP_BACK, 32'h0);
    add_request(ACT_POP_FRONT, 32'h0);

    // Fill and drain bursts drive the deque to full and to empty; mixed bursts
    // draw values from a small pool so that deletes find matches and duplicates.
    generated = 0;
    while (generated < RANDOM_ITEMS) begin
      kind  = $urandom_range(9);
      burst = $urandom_range(16, 22);
      for (int j = 0; j < burst; j++) begin
        if (kind < 2) act = $urandom_range(1) ? ACT_PUSH_BACK : ACT_PUSH_FRONT;
        else if (kind < 4) act = $urandom_range(1) ? ACT_POP_BACK : ACT_POP_FRONT;
        else act = random_action();
        add_request(act, pick_value());
      end
      generated += burst;
    end
    total = pending_requests.size();

    repeat (7) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 59;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 59;
        end
        default: begin
          send_idle_pct  = 19;
          recv_stall_pct = 19;
        end
      endcase
      while (accepted_beats < (p + 1) * total / 4) @(posedge clk_i);
    end

    while (pending_requests.size() != 0 || in_valid_i) @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("tb_double_ended_queue_with_delete: done, clean");
    end else begin
      $display("tb_double_ended_queue_with_delete: done, errors");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb_double_ended_queue_with_delete: done, errors");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/dqd_pkg.sv
hw/rtl/dqd_ram.sv
hw/rtl/dqd_ctrl.sv
hw/rtl/double_ended_queue_with_delete.sv
tb/sv/tb_double_ended_queue_with_delete.sv
